// File: hdl/rzpw_pkg.sv
// Shared types and constants for the radar zone proximity warner.
package rzpw_pkg;

  localparam int unsigned ZONES      = 3;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ANGLE_W    = 11;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned ZONE_W     = 2;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [DIST_W-1:0]         NONE_MM    = 16'hFFFF;
  localparam logic signed [ANGLE_W-1:0] LEFT_EDGE  = -11'sd200;
  localparam logic signed [ANGLE_W-1:0] RIGHT_EDGE = 11'sd200;
  localparam logic [DEB_W-1:0]          COUNT_CAP  = 8'd255;

  localparam logic [ZONE_W-1:0] ZONE_LEFT   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_CENTRE = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_RIGHT  = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_SAFE      = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_ATTENTION = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_WARNING   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_DANGER    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ATTENTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd3;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [DIST_W-1:0] mm;
    logic              hit;
    logic              last;
  } op_t;

  typedef struct packed {
    logic [DIST_W-1:0] attention;
    logic [DIST_W-1:0] warning;
    logic [DIST_W-1:0] danger;
    logic [DEB_W-1:0]  debounce;
  } cfg_t;

  typedef struct packed {
    logic [ZONES-1:0][LEVEL_W-1:0] level;
    logic [ZONES-1:0][DIST_W-1:0]  nearest;
    logic [LEVEL_W-1:0]            overall;
    logic [ZONE_W-1:0]             direction;
    logic [DIST_W-1:0]             closest;
  } res_t;

endpackage

// File: hdl/radar_zone_proximity_warner.sv
// Top level of the radar zone proximity warner: configuration registers and block wiring.
//
// Accepts one radar item per clock cycle, sustained, as long as results are taken. The
// front end bins each target into left, centre or right and counts targets per frame; a
// two-entry queue feeds the back end, which folds each target into its zone minimum as it
// is taken. On the last item of a frame the back end maps the zone distances to levels,
// advances the debounce counters and loads the result register; the result becomes valid
// in the cycle after the back end takes the frame-end item, and the next frame's items keep
// flowing while it waits to be taken. Threshold and debounce registers are written through
// the cfg port and take effect at the next frame end.
module radar_zone_proximity_warner
  import rzpw_pkg::*;
#(
  parameter int MAX_TARGETS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [DIST_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] target_angle_i,
  input  logic [DIST_W-1:0]         target_distance_i,
  input  logic                      target_valid_i,
  input  logic                      frame_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [LEVEL_W-1:0]        left_level_o,
  output logic [LEVEL_W-1:0]        centre_level_o,
  output logic [LEVEL_W-1:0]        right_level_o,
  output logic [DIST_W-1:0]         left_nearest_mm_o,
  output logic [DIST_W-1:0]         centre_nearest_mm_o,
  output logic [DIST_W-1:0]         right_nearest_mm_o,
  output logic [LEVEL_W-1:0]        overall_level_o,
  output logic [ZONE_W-1:0]         closest_direction_o,
  output logic [DIST_W-1:0]         closest_mm_o
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  op_t  push_data, pop_data;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attention <= 16'd2000;
      cfg_q.warning   <= 16'd1000;
      cfg_q.danger    <= 16'd500;
      cfg_q.debounce  <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ATTENTION: cfg_q.attention <= cfg_data_i;
        REG_WARNING:   cfg_q.warning   <= cfg_data_i;
        REG_DANGER:    cfg_q.danger    <= cfg_data_i;
        REG_DEBOUNCE:  cfg_q.debounce  <= cfg_data_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  rzpw_front #(
    .MAX_TARGETS(MAX_TARGETS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_angle_i   (target_angle_i),
    .target_distance_i(target_distance_i),
    .target_valid_i   (target_valid_i),
    .frame_last_i     (frame_last_i),
    .op_valid_o       (push_valid),
    .op_ready_i       (push_ready),
    .op_o             (push_data)
  );

  rzpw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  rzpw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (pop_valid),
    .op_ready_o (pop_ready),
    .op_i       (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign left_level_o        = res.level[0];
  assign centre_level_o      = res.level[1];
  assign right_level_o       = res.level[2];
  assign left_nearest_mm_o   = res.nearest[0];
  assign centre_nearest_mm_o = res.nearest[1];
  assign right_nearest_mm_o  = res.nearest[2];
  assign overall_level_o     = res.overall;
  assign closest_direction_o = res.direction;
  assign closest_mm_o        = res.closest;

endmodule

// File: hdl/rzpw_front.sv
// Front end: target counting, zone binning and distance saturation.
module rzpw_front
  import rzpw_pkg::*;
#(
  parameter int MAX_TARGETS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] target_angle_i,
  input  logic [DIST_W-1:0]         target_distance_i,
  input  logic                      target_valid_i,
  input  logic                      frame_last_i,
  output logic                      op_valid_o,
  input  logic                      op_ready_i,
  output op_t                       op_o
);

  localparam int CntW = $clog2(MAX_TARGETS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hit;
  logic            xfer;

  assign hit        = target_valid_i && (cnt_q < CntW'(MAX_TARGETS));
  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i && (hit || frame_last_i);
  assign xfer       = in_valid_i && in_ready_o;

  always_comb begin
    op_o.hit  = hit;
    op_o.last = frame_last_i;
    op_o.mm   = (target_distance_i == NONE_MM) ? NONE_MM - 16'd1 : target_distance_i;
    if (target_angle_i < LEFT_EDGE) begin
      op_o.zone = ZONE_LEFT;
    end else if (target_angle_i > RIGHT_EDGE) begin
      op_o.zone = ZONE_RIGHT;
    end else begin
      op_o.zone = ZONE_CENTRE;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (xfer) begin
      if (frame_last_i) begin
        cnt_d = '0;
      end else if (hit) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/rzpw_queue.sv
// Short queue of classified items between the front end and the back end.
module rzpw_queue
  import rzpw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_data_o
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);

  op_t             mem_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

// File: hdl/rzpw_back.sv
// Back end: zone minima, frame-end level mapping, debounce and result register.
module rzpw_back
  import rzpw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic op_valid_i,
  output logic op_ready_o,
  input  op_t  op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic [ZONES-1:0][DIST_W-1:0]  min_q, min_d, merged;
  logic [ZONES-1:0][LEVEL_W-1:0] pend_q, pend_d, rep_q, rep_d, lvl;
  logic [ZONES-1:0][DEB_W-1:0]   stab_q, stab_d;
  logic                          out_valid_q;
  res_t                          res_q, res_d;
  logic                          pop, eval;
  logic [LEVEL_W-1:0]            top;
  logic [ZONE_W-1:0]             best_zone;
  logic [DIST_W-1:0]             best_mm;

  assign op_ready_o  = !op_i.last || !out_valid_q || out_ready_i;
  assign pop         = op_valid_i && op_ready_o;
  assign eval        = pop && op_i.last;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    for (int z = 0; z < ZONES; z++) begin
      merged[z] = min_q[z];
      if (op_i.hit && op_i.zone == ZONE_W'(z) && op_i.mm < min_q[z]) begin
        merged[z] = op_i.mm;
      end
      if (merged[z] == NONE_MM) begin
        lvl[z] = LVL_SAFE;
      end else if (merged[z] <= cfg_i.danger) begin
        lvl[z] = LVL_DANGER;
      end else if (merged[z] <= cfg_i.warning) begin
        lvl[z] = LVL_WARNING;
      end else if (merged[z] <= cfg_i.attention) begin
        lvl[z] = LVL_ATTENTION;
      end else begin
        lvl[z] = LVL_SAFE;
      end
      pend_d[z] = pend_q[z];
      stab_d[z] = stab_q[z];
      rep_d[z]  = rep_q[z];
      if (eval) begin
        if (lvl[z] != pend_q[z]) begin
          pend_d[z] = lvl[z];
          stab_d[z] = '0;
        end else if (stab_q[z] < COUNT_CAP) begin
          stab_d[z] = stab_q[z] + DEB_W'(1);
        end
        if (stab_d[z] >= cfg_i.debounce) begin
          rep_d[z] = pend_d[z];
        end
      end
      min_d[z] = pop ? (op_i.last ? NONE_MM : merged[z]) : min_q[z];
    end
  end

  always_comb begin
    top       = LVL_SAFE;
    best_mm   = NONE_MM;
    best_zone = ZONE_CENTRE;
    for (int z = 0; z < ZONES; z++) begin
      if (rep_d[z] > top) begin
        top = rep_d[z];
      end
      if (merged[z] < best_mm) begin
        best_mm   = merged[z];
        best_zone = ZONE_W'(z);
      end
    end
    res_d.level     = rep_d;
    res_d.nearest   = merged;
    res_d.overall   = top;
    res_d.direction = best_zone;
    res_d.closest   = best_mm;
  end

  always_ff @(posedge clk_i) begin
    if (eval) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < ZONES; z++) begin
        min_q[z]  <= NONE_MM;
        pend_q[z] <= LVL_SAFE;
        stab_q[z] <= '0;
        rep_q[z]  <= LVL_SAFE;
      end
      out_valid_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      pend_q <= pend_d;
      stab_q <= stab_d;
      rep_q  <= rep_d;
      if (eval) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_min_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval |=> (min_q[0] == NONE_MM && min_q[1] == NONE_MM && min_q[2] == NONE_MM))
    else $error("zone minima not cleared after frame end");

  a_rep_only_on_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eval |=> $stable(rep_q) && $stable(pend_q) && $stable(stab_q))
    else $error("debounce state changed outside frame end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !eval)
    else $error("pending result overwritten");

  a_overall_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.overall >= res_q.level[0] && res_q.overall >= res_q.level[1]
                     && res_q.overall >= res_q.level[2]))
    else $error("overall level below a zone level");

endmodule
